// ===== design/nmac_pkg.sv =====
// nmac_pkg: shared types, codes and table builders for the neuron mac/activation core
// used by nmac_ctrl, nmac_datapath and neuron_mac_activation_core; no dependencies
package nmac_pkg;

    // activation mode codes
    localparam logic [2:0] MODE_STEP    = 3'd0;
    localparam logic [2:0] MODE_LINEAR  = 3'd1;
    localparam logic [2:0] MODE_RELU    = 3'd2;
    localparam logic [2:0] MODE_LEAKY   = 3'd3;
    localparam logic [2:0] MODE_PRELU   = 3'd4;
    localparam logic [2:0] MODE_SIGMOID = 3'd5;
    localparam logic [2:0] MODE_TANH    = 3'd6;

    localparam int MODE_W = 3;
    localparam int CFG_INDEX_W = 3;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ACT_MODE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIAS      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA     = 3'd3;

    localparam int ALPHA_RESET = 6;

    // fixed-point layout
    localparam int FRAC      = 8;
    localparam int PROD_FRAC = 16;
    localparam int LUT_SHIFT = 12;
    localparam int ONE_FIX   = 256;
    localparam int CHUNK_W   = 16;

    localparam logic [63:0] ONE31 = 64'h0000_0000_8000_0000;
    localparam logic [63:0] HALF31 = 64'h0000_0000_4000_0000;

    typedef struct packed {
        logic prod_load;
        logic sum_load;
        logic mul_init;
        logic mul_step;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_mul;
        logic out_free;
    } dp_status_t;

    // restoring division, only evaluated while building the tables
    function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[63:0], n[i]};
            if (r >= {1'b0, d})
            begin
                r = r - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-1/16) in q31 from a truncated taylor series in q62
    function automatic logic [63:0] exp_step();
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        term = 64'h4000_0000_0000_0000;
        pos  = term;
        neg  = '0;
        for (int k = 1; k <= 20; k++)
        begin
            term = udiv64(term, 64'(16 * k));
            if (k[0])
                neg = neg + term;
            else
                pos = pos + term;
        end
        return ((pos - neg) + HALF31) >> 31;
    endfunction

    // exp(-n/16) in q31
    function automatic logic [63:0] pow_e(int n);
        logic [63:0] e;
        logic [63:0] p;
        e = exp_step();
        p = ONE31;
        for (int i = 1; i <= n; i++)
            p = (p * e + HALF31) >> 31;
        return p;
    endfunction

    function automatic logic signed [31:0] sig_entry(int i, int depth);
        int j;
        int m;
        logic [63:0] e;
        logic [63:0] d;
        logic [63:0] num;
        j = i - (depth >>> 1);
        m = (j < 0) ? -j : j;
        e = pow_e(m);
        d = ONE31 + e;
        num = (j >= 0) ? ONE31 : e;
        return 32'(udiv64(num * 64'd256 + (d >> 1), d));
    endfunction

    function automatic logic signed [31:0] tanh_entry(int i, int depth);
        int j;
        int m;
        logic [63:0] e;
        logic [63:0] d;
        logic [63:0] t;
        logic signed [31:0] tv;
        j = i - (depth >>> 1);
        m = (j < 0) ? -j : j;
        e = pow_e(2 * m);
        d = ONE31 + e;
        t = udiv64((ONE31 - e) * 64'd256 + (d >> 1), d);
        tv = 32'(t);
        return (j < 0) ? -tv : tv;
    endfunction

endpackage

// ===== design/nmac_ctrl.sv =====
// nmac_ctrl: sequencing state machine for the neuron mac/activation core
// depends on nmac_pkg (command and status structs)
module nmac_ctrl #(
    parameter int ACC_WIDTH = 48
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   last,
    input  nmac_pkg::dp_status_t   status,
    output nmac_pkg::ctrl_cmd_t    cmd
);

    localparam int NCHUNK = (ACC_WIDTH + nmac_pkg::CHUNK_W - 1) / nmac_pkg::CHUNK_W;
    localparam int CNT_W  = $clog2(NCHUNK);

    localparam logic [2:0] ST_ACC   = 3'd0;
    localparam logic [2:0] ST_DRAIN = 3'd1;
    localparam logic [2:0] ST_SUM   = 3'd2;
    localparam logic [2:0] ST_EVAL  = 3'd3;
    localparam logic [2:0] ST_MUL   = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             accept;

    assign in_ready = (state_reg == ST_ACC);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cmd.prod_load = accept;
        cmd.sum_load  = 1'b0;
        cmd.mul_init  = 1'b0;
        cmd.mul_step  = 1'b0;
        cmd.out_load  = 1'b0;
        case (state_reg)
            ST_ACC:
            begin
                if (accept && last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                // last product lands in the accumulator this cycle
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum_load = 1'b1;
                state_next   = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.mul_init = 1'b1;
                if (status.need_mul)
                begin
                    cnt_next   = CNT_W'(NCHUNK - 1);
                    state_next = ST_MUL;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_FIN;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            ST_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_ACC;
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACC;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result loaded while output register still occupied");

    a_last_stops_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && last) |=> !in_ready)
        else $error("input still accepted after the closing beat");

    a_mul_follows_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL && !status.need_mul) |=> !cmd.mul_step)
        else $error("multiply stepped for a mode that needs none");

endmodule

// ===== design/nmac_datapath.sv =====
// nmac_datapath: config registers, mac accumulator, chunked alpha multiply, activation
// and output register; depends on nmac_pkg for codes, layout constants and tables
module nmac_datapath #(
    parameter int DATA_WIDTH = 16,
    parameter int ACC_WIDTH  = 48,
    parameter int LUT_DEPTH  = 256
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [nmac_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [DATA_WIDTH-1:0]                 cfg_data,
    input  logic signed [DATA_WIDTH-1:0]          in_value,
    input  logic signed [DATA_WIDTH-1:0]          in_weight,
    input  nmac_pkg::ctrl_cmd_t                   cmd,
    output nmac_pkg::dp_status_t                  status,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [DATA_WIDTH-1:0]          activation_out,
    output logic                                  saturated
);

    localparam int CW     = nmac_pkg::CHUNK_W;
    localparam int PRODW  = 2 * DATA_WIDTH;
    localparam int EXTW   = (PRODW > ACC_WIDTH) ? PRODW : ACC_WIDTH;
    localparam int NCHUNK = (ACC_WIDTH + CW - 1) / CW;
    localparam int MSW    = NCHUNK * CW;
    localparam int PW     = MSW + DATA_WIDTH;
    localparam int QW     = PW - nmac_pkg::PROD_FRAC + 1;
    localparam int CMPW   = ACC_WIDTH + DATA_WIDTH;
    localparam int IW     = $clog2(LUT_DEPTH);

    localparam logic [DATA_WIDTH-1:0] QMAX_V = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] QMIN_V = ~QMAX_V;
    localparam logic signed [ACC_WIDTH-1:0] QMAX_ACC = ACC_WIDTH'(QMAX_V);
    localparam logic signed [ACC_WIDTH-1:0] HALF_ACC = ACC_WIDTH'(LUT_DEPTH / 2);
    localparam logic [QW-1:0] QLIM = QW'(1) << (DATA_WIDTH - 1);

    // configuration
    logic [nmac_pkg::MODE_W-1:0]  mode_reg;
    logic signed [DATA_WIDTH-1:0] thr_reg;
    logic signed [DATA_WIDTH-1:0] bias_reg;
    logic signed [DATA_WIDTH-1:0] alpha_reg;

    // mac
    logic signed [PRODW-1:0]      prod_reg;
    logic                         prod_valid_reg;
    logic signed [EXTW-1:0]       prod_ext;
    logic signed [ACC_WIDTH-1:0]  acc_reg;
    logic signed [ACC_WIDTH-1:0]  acc_next;
    logic signed [ACC_WIDTH-1:0]  sum_reg;
    logic signed [ACC_WIDTH-1:0]  bias_acc;

    // magnitude multiply
    logic [ACC_WIDTH-1:0]         mag_sum;
    logic [DATA_WIDTH-1:0]        mag_alpha;
    logic [MSW-1:0]               mag_s_reg;
    logic [DATA_WIDTH-1:0]        mag_a_reg;
    logic                         neg_reg;
    logic [PW-1:0]                mprod_reg;
    logic [CW-1:0]                chunk;

    // activation
    logic                         sum_pos;
    logic signed [ACC_WIDTH-1:0]  sh8;
    logic signed [ACC_WIDTH-1:0]  q12;
    logic signed [ACC_WIDTH-1:0]  q12_off;
    logic signed [CMPW-1:0]       sum_w;
    logic signed [CMPW-1:0]       thr_w;
    logic [QW-1:0]                q_mul;
    logic [DATA_WIDTH-1:0]        mul_val;
    logic                         mul_sat;
    logic [DATA_WIDTH-1:0]        relu_val;
    logic                         relu_sat;
    logic [IW-1:0]                lut_idx;
    logic [DATA_WIDTH-1:0]        sig_lut [LUT_DEPTH];
    logic [DATA_WIDTH-1:0]        tanh_lut [LUT_DEPTH];
    logic [DATA_WIDTH-1:0]        res_val;
    logic                         res_sat;

    logic                         out_valid_reg;
    logic [DATA_WIDTH-1:0]        act_reg;
    logic                         sat_reg;

    // activation tables, fixed at elaboration
    for (genvar g = 0; g < LUT_DEPTH; g++)
    begin : g_lut
        localparam logic signed [31:0] SIG_V  = nmac_pkg::sig_entry(g, LUT_DEPTH);
        localparam logic signed [31:0] TANH_V = nmac_pkg::tanh_entry(g, LUT_DEPTH);
        assign sig_lut[g]  = SIG_V[DATA_WIDTH-1:0];
        assign tanh_lut[g] = TANH_V[DATA_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= nmac_pkg::MODE_STEP;
            thr_reg   <= '0;
            bias_reg  <= '0;
            alpha_reg <= DATA_WIDTH'(nmac_pkg::ALPHA_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                nmac_pkg::CFG_ACT_MODE:  mode_reg  <= cfg_data[nmac_pkg::MODE_W-1:0];
                nmac_pkg::CFG_THRESHOLD: thr_reg   <= cfg_data;
                nmac_pkg::CFG_BIAS:      bias_reg  <= cfg_data;
                nmac_pkg::CFG_ALPHA:     alpha_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // product is registered, then added in the following cycle (wraps at the accumulator width)
    assign prod_ext = EXTW'(prod_reg);
    assign bias_acc = ACC_WIDTH'(EXTW'(bias_reg) <<< nmac_pkg::FRAC);

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.sum_load)
            acc_next = '0;
        else if (prod_valid_reg)
            acc_next = acc_reg + prod_ext[ACC_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            acc_reg        <= '0;
        end
        else
        begin
            prod_valid_reg <= cmd.prod_load;
            acc_reg        <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prod_load)
            prod_reg <= PRODW'(in_value) * PRODW'(in_weight);
        if (cmd.sum_load)
            sum_reg <= acc_reg + bias_acc;
    end

    // sign-magnitude multiply of sum by alpha, one 16-bit chunk of |sum| a cycle
    assign mag_sum   = sum_reg[ACC_WIDTH-1] ? ACC_WIDTH'(-sum_reg) : sum_reg;
    assign mag_alpha = alpha_reg[DATA_WIDTH-1] ? DATA_WIDTH'(-alpha_reg) : alpha_reg;
    assign chunk     = mag_s_reg[MSW-1 -: CW];

    always_ff @(posedge clk)
    begin
        if (cmd.mul_init)
        begin
            mag_s_reg <= MSW'(mag_sum);
            mag_a_reg <= mag_alpha;
            neg_reg   <= sum_reg[ACC_WIDTH-1] ^ alpha_reg[DATA_WIDTH-1];
            mprod_reg <= '0;
        end
        else if (cmd.mul_step)
        begin
            mag_s_reg <= mag_s_reg << CW;
            mprod_reg <= (mprod_reg << CW) + (PW'(chunk) * PW'(mag_a_reg));
        end
    end

    assign sum_pos = !sum_reg[ACC_WIDTH-1] && (sum_reg != '0);

    assign status.need_mul = (mode_reg == nmac_pkg::MODE_LINEAR) ||
                             (((mode_reg == nmac_pkg::MODE_LEAKY) ||
                               (mode_reg == nmac_pkg::MODE_PRELU)) && !sum_pos);
    assign status.out_free = !out_valid_reg || out_ready;

    // floor of the scaled product: negative results round the magnitude up
    always_comb
    begin
        q_mul = QW'(mprod_reg >> nmac_pkg::PROD_FRAC) +
                QW'(neg_reg && (mprod_reg[nmac_pkg::PROD_FRAC-1:0] != '0));
        mul_sat = 1'b0;
        if (neg_reg)
        begin
            if (q_mul > QLIM)
            begin
                mul_val = QMIN_V;
                mul_sat = 1'b1;
            end
            else
            begin
                mul_val = DATA_WIDTH'(-q_mul);
            end
        end
        else
        begin
            if (q_mul > QLIM - 1'b1)
            begin
                mul_val = QMAX_V;
                mul_sat = 1'b1;
            end
            else
            begin
                mul_val = q_mul[DATA_WIDTH-1:0];
            end
        end
    end

    assign sh8      = sum_reg >>> nmac_pkg::FRAC;
    assign relu_sat = sh8 > QMAX_ACC;
    assign relu_val = relu_sat ? QMAX_V : sh8[DATA_WIDTH-1:0];

    assign sum_w = CMPW'(sum_reg);
    assign thr_w = CMPW'(thr_reg) <<< nmac_pkg::FRAC;

    // q4.4 table index, clamped to the table span
    assign q12     = sum_reg >>> nmac_pkg::LUT_SHIFT;
    assign q12_off = q12 + HALF_ACC;

    always_comb
    begin
        if (q12 < -HALF_ACC)
            lut_idx = '0;
        else if (q12 > HALF_ACC - 1)
            lut_idx = IW'(LUT_DEPTH - 1);
        else
            lut_idx = q12_off[IW-1:0];
    end

    always_comb
    begin
        res_val = '0;
        res_sat = 1'b0;
        case (mode_reg)
            nmac_pkg::MODE_STEP:
            begin
                res_val = (sum_w < thr_w) ? '0 : DATA_WIDTH'(nmac_pkg::ONE_FIX);
            end
            nmac_pkg::MODE_LINEAR:
            begin
                res_val = mul_val;
                res_sat = mul_sat;
            end
            nmac_pkg::MODE_RELU:
            begin
                if (sum_pos)
                begin
                    res_val = relu_val;
                    res_sat = relu_sat;
                end
            end
            nmac_pkg::MODE_LEAKY, nmac_pkg::MODE_PRELU:
            begin
                res_val = sum_pos ? relu_val : mul_val;
                res_sat = sum_pos ? relu_sat : mul_sat;
            end
            nmac_pkg::MODE_SIGMOID:
            begin
                res_val = sig_lut[lut_idx];
            end
            nmac_pkg::MODE_TANH:
            begin
                res_val = tanh_lut[lut_idx];
            end
            default:
            begin
                res_val = '0;
                res_sat = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            act_reg <= res_val;
            sat_reg <= res_sat;
        end
    end

    assign out_valid      = out_valid_reg;
    assign activation_out = act_reg;
    assign saturated      = sat_reg;

    a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sum_load |=> (acc_reg == '0))
        else $error("accumulator not cleared after the sum was taken");

    a_sat_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && sat_reg) |-> (act_reg == QMAX_V || act_reg == QMIN_V))
        else $error("saturation flagged on a value off the rails");

    a_no_prod_at_sum: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sum_load |-> !prod_valid_reg)
        else $error("product still in flight when the sum was taken");

endmodule

// ===== design/neuron_mac_activation_core.sv =====
// neuron_mac_activation_core: top level of the neuron mac/activation block
// depends on nmac_pkg, nmac_ctrl and nmac_datapath
//
// usage:
//   input channel (in_valid/in_ready): one beat per value/weight pair, signed q8.8;
//   last marks the closing beat of an evaluation. every beat is multiplied and
//   summed into a wrapping accumulator; the closing beat yields one result.
//   output channel (out_valid/out_ready): activation_out (q8.8) and saturated.
//   config port: cfg_we writes cfg_data to register cfg_index (0 act_mode,
//   1 threshold, 2 bias, 3 alpha); other indexes are ignored. write only when idle.
// throughput: one beat per cycle while an evaluation streams in. after the closing
//   beat input is held off while the last product and the bias are added and the
//   activation worked out; when the alpha multiply is needed (linear, or leaky/
//   parametric relu on a non-positive sum) it steps 16 bits of the sum per cycle
//   through one 16 x DATA_WIDTH multiplier. input stays held off until the output register is free.
// reset: accumulator cleared, act_mode step, threshold and bias 0, alpha 6.
// stall: the result waits in the output register; the next evaluation streams in
//   meanwhile; its result and any further input wait until that register drains.
module neuron_mac_activation_core #(
    parameter int DATA_WIDTH = 16,
    parameter int ACC_WIDTH  = 48,
    parameter int LUT_DEPTH  = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [DATA_WIDTH-1:0]      in_value,
    input  logic signed [DATA_WIDTH-1:0]      in_weight,
    input  logic                              last,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [DATA_WIDTH-1:0]      activation_out,
    output logic                              saturated,
    input  logic                              cfg_we,
    input  logic [nmac_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [DATA_WIDTH-1:0]             cfg_data
);

    nmac_pkg::ctrl_cmd_t  cmd;
    nmac_pkg::dp_status_t status;

    nmac_ctrl #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .last     (last),
        .status   (status),
        .cmd      (cmd)
    );

    nmac_datapath #(
        .DATA_WIDTH (DATA_WIDTH),
        .ACC_WIDTH  (ACC_WIDTH),
        .LUT_DEPTH  (LUT_DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_value       (in_value),
        .in_weight      (in_weight),
        .cmd            (cmd),
        .status         (status),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .activation_out (activation_out),
        .saturated      (saturated)
    );

endmodule

// ===== tb/neuron_result_checker.sv =====
// neuron_result_checker: watches the beat, result and register ports of the neuron core,
// predicts each activation and compares it with what comes out
// depends on nmac_pkg for the mode codes, register indexes and fixed-point layout
module neuron_result_checker #(
    parameter int DATA_WIDTH = 16,
    parameter int ACC_WIDTH  = 48,
    parameter int LUT_DEPTH  = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic signed [DATA_WIDTH-1:0]        in_value,
    input  logic signed [DATA_WIDTH-1:0]        in_weight,
    input  logic                                last,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic signed [DATA_WIDTH-1:0]        activation_out,
    input  logic                                saturated,
    input  logic                                cfg_we,
    input  logic [nmac_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [DATA_WIDTH-1:0]               cfg_data,
    output int                                  failures,
    output int                                  outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint Q_MAX = (longint'(1) << (DATA_WIDTH - 1)) - 1;
    localparam longint Q_MIN = -Q_MAX - 1;
    localparam int HALF_LUT = LUT_DEPTH / 2;
    localparam longint unsigned UNIT_Q31 = 64'd1 << 31;
    localparam longint unsigned HALF_Q31 = 64'd1 << 30;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] act;
        logic                         sat;
    } activation_t;

    activation_t predicted_activations [$];

    logic [nmac_pkg::MODE_W-1:0]  mode_r;
    logic signed [DATA_WIDTH-1:0] thr_r;
    logic signed [DATA_WIDTH-1:0] bias_r;
    logic signed [DATA_WIDTH-1:0] alpha_r;
    logic signed [ACC_WIDTH-1:0]  mac_sum;

    longint sigmoid_lut [LUT_DEPTH];
    longint tanh_lut [LUT_DEPTH];

    // exp(-n/16) powers in q31, then the two activation tables indexed by the q4.4 sum
    initial
    begin
        longint unsigned term;
        longint unsigned pos_sum;
        longint unsigned neg_sum;
        longint unsigned decay;
        longint unsigned e;
        longint unsigned d;
        longint unsigned num;
        longint unsigned t;
        longint unsigned powers [LUT_DEPTH+1];
        int j;
        int m;
        term = 64'd1 << 62;
        pos_sum = term;
        neg_sum = 0;
        for (int k = 1; k <= 20; k++)
        begin
            term = term / 64'(16 * k);
            if (k % 2 == 1)
                neg_sum = neg_sum + term;
            else
                pos_sum = pos_sum + term;
        end
        decay = (pos_sum - neg_sum + HALF_Q31) >> 31;
        powers[0] = UNIT_Q31;
        for (int i = 1; i <= LUT_DEPTH; i++)
            powers[i] = (powers[i-1] * decay + HALF_Q31) >> 31;
        for (int i = 0; i < LUT_DEPTH; i++)
        begin
            j = i - HALF_LUT;
            m = (j < 0) ? -j : j;
            e = powers[m];
            d = UNIT_Q31 + e;
            num = (j >= 0) ? UNIT_Q31 : e;
            sigmoid_lut[i] = longint'((num * 256 + d / 2) / d);
            e = powers[2 * m];
            d = UNIT_Q31 + e;
            t = ((UNIT_Q31 - e) * 256 + d / 2) / d;
            tanh_lut[i] = (j < 0) ? -longint'(t) : longint'(t);
        end
    end

    function automatic activation_t clip_q88(longint v);
        activation_t r;
        r.sat = 1'b0;
        if (v > Q_MAX)
        begin
            r.act = DATA_WIDTH'(Q_MAX);
            r.sat = 1'b1;
        end
        else if (v < Q_MIN)
        begin
            r.act = DATA_WIDTH'(Q_MIN);
            r.sat = 1'b1;
        end
        else
            r.act = DATA_WIDTH'(v);
        return r;
    endfunction

    // s is the biased sum in q32.16 (ACC_WIDTH bits, 16 of them fraction)
    function automatic activation_t activate(longint s);
        activation_t r;
        longint q;
        r = '0;
        case (mode_r)
            nmac_pkg::MODE_STEP:
                r.act = (s < longint'(thr_r) * nmac_pkg::ONE_FIX)
                        ? '0 : DATA_WIDTH'(nmac_pkg::ONE_FIX);
            nmac_pkg::MODE_LINEAR:
                r = clip_q88((s * longint'(alpha_r)) >>> nmac_pkg::PROD_FRAC);
            nmac_pkg::MODE_RELU:
                if (s > 0)
                    r = clip_q88(s >>> nmac_pkg::FRAC);
            nmac_pkg::MODE_LEAKY, nmac_pkg::MODE_PRELU:
                r = (s > 0) ? clip_q88(s >>> nmac_pkg::FRAC)
                            : clip_q88((s * longint'(alpha_r)) >>> nmac_pkg::PROD_FRAC);
            nmac_pkg::MODE_SIGMOID, nmac_pkg::MODE_TANH:
            begin
                q = s >>> nmac_pkg::LUT_SHIFT;
                if (q < -HALF_LUT)
                    q = -HALF_LUT;
                if (q > HALF_LUT - 1)
                    q = HALF_LUT - 1;
                r.act = (mode_r == nmac_pkg::MODE_SIGMOID)
                        ? DATA_WIDTH'(sigmoid_lut[int'(q) + HALF_LUT])
                        : DATA_WIDTH'(tanh_lut[int'(q) + HALF_LUT]);
            end
            default:
                r = '0;
        endcase
        return r;
    endfunction

    always @(posedge clk)
    begin
        longint prod;
        longint bias_scaled;
        logic signed [ACC_WIDTH-1:0] total;
        activation_t want;
        if (!rst_n)
        begin
            mode_r = nmac_pkg::MODE_STEP;
            thr_r = '0;
            bias_r = '0;
            alpha_r = DATA_WIDTH'(nmac_pkg::ALPHA_RESET);
            mac_sum = '0;
            failures = 0;
            predicted_activations.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    nmac_pkg::CFG_ACT_MODE:  mode_r = cfg_data[nmac_pkg::MODE_W-1:0];
                    nmac_pkg::CFG_THRESHOLD: thr_r = cfg_data;
                    nmac_pkg::CFG_BIAS:      bias_r = cfg_data;
                    nmac_pkg::CFG_ALPHA:     alpha_r = cfg_data;
                    default:                 ;
                endcase
            end

            if (in_valid && in_ready)
            begin
                prod = longint'(in_value) * longint'(in_weight);
                mac_sum = mac_sum + prod[ACC_WIDTH-1:0];
                if (last)
                begin
                    bias_scaled = longint'(bias_r) * nmac_pkg::ONE_FIX;
                    total = mac_sum + bias_scaled[ACC_WIDTH-1:0];
                    mac_sum = '0;
                    predicted_activations.push_back(activate(longint'(total)));
                end
            end

            if (out_valid && out_ready)
            begin
                if (predicted_activations.size() == 0)
                begin
                    failures++;
                    $display("%0t: result %0d sat %0b arrived with nothing predicted",
                             $time, activation_out, saturated);
                end
                else
                begin
                    want = predicted_activations.pop_front();
                    if (activation_out !== want.act)
                    begin
                        failures++;
                        $display("%0t: activation_out expected %0d got %0d",
                                 $time, want.act, activation_out);
                    end
                    if (saturated !== want.sat)
                    begin
                        failures++;
                        $display("%0t: saturated expected %0b got %0b",
                                 $time, want.sat, saturated);
                    end
                end
            end
        end
        outstanding <= predicted_activations.size();
    end

endmodule

// ===== tb/neuron_mac_activation_core_test.sv =====
// neuron_mac_activation_core_test: drives beats, register writes and output back-pressure
// into the neuron core and gives the verdict; checking sits in neuron_result_checker
// depends on nmac_pkg, neuron_mac_activation_core and neuron_result_checker
module neuron_mac_activation_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_WIDTH = 16;
    localparam int ACC_WIDTH = 48;
    localparam int LUT_DEPTH = 256;
    localparam int RANDOM_PHASES = 22;
    localparam int PHASE_BEATS = 32;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD = 300;
    localparam int CYCLE_LIMIT = 100000;

    typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} ready_pattern_t;

    logic                                clk;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_ready;
    logic signed [DATA_WIDTH-1:0]        in_value;
    logic signed [DATA_WIDTH-1:0]        in_weight;
    logic                                last;
    logic                                out_valid;
    logic                                out_ready;
    logic signed [DATA_WIDTH-1:0]        activation_out;
    logic                                saturated;
    logic                                cfg_we;
    logic [nmac_pkg::CFG_INDEX_W-1:0]    cfg_index;
    logic [DATA_WIDTH-1:0]               cfg_data;

    int failures;
    int outstanding;
    int cycle_count = 0;
    int beats_left_in_burst = 0;
    int max_gap = 3;
    bit hold_off_req = 1'b0;

    neuron_mac_activation_core #(
        .DATA_WIDTH(DATA_WIDTH),
        .ACC_WIDTH(ACC_WIDTH),
        .LUT_DEPTH(LUT_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_value(in_value),
        .in_weight(in_weight),
        .last(last),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .activation_out(activation_out),
        .saturated(saturated),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    neuron_result_checker #(
        .DATA_WIDTH(DATA_WIDTH),
        .ACC_WIDTH(ACC_WIDTH),
        .LUT_DEPTH(LUT_DEPTH)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_value(in_value),
        .in_weight(in_weight),
        .last(last),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .activation_out(activation_out),
        .saturated(saturated),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .failures(failures),
        .outstanding(outstanding)
    );

    initial
        clk = 1'b0;

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // mostly small q8.8 numbers so the tables see unclamped indexes, plus full range and extremes
    function automatic logic [DATA_WIDTH-1:0] rand_q88();
        case ($urandom_range(0, 9))
            0:
                case ($urandom_range(0, 4))
                    0:       return 16'h8000;
                    1:       return 16'h7fff;
                    2:       return 16'h0000;
                    3:       return 16'hffff;
                    default: return 16'h0001;
                endcase
            1, 2, 3:
                return DATA_WIDTH'($urandom);
            4, 5, 6, 7:
                return DATA_WIDTH'($urandom_range(0, 2047)) - 16'd1024;
            default:
                return DATA_WIDTH'($urandom_range(0, 16383)) - 16'd8192;
        endcase
    endfunction

    // valid stays up across back-to-back beats, dropped only for a gap between bursts
    task automatic send_beat(input logic [DATA_WIDTH-1:0] v, input logic [DATA_WIDTH-1:0] w,
                             input logic closing);
        int gap;
        if (beats_left_in_burst == 0)
        begin
            beats_left_in_burst = $urandom_range(1, 24);
            gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        beats_left_in_burst--;
        in_valid <= 1'b1;
        in_value <= v;
        in_weight <= w;
        last <= closing;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic stop_input();
        in_valid <= 1'b0;
        beats_left_in_burst = 0;
    endtask

    // block is idle once nothing is predicted and the longest activation has had time to finish
    task automatic wait_for_results();
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // all four registers plus one write to an unused index, which must change nothing
    task automatic load_settings(input logic [nmac_pkg::MODE_W-1:0] mode,
                                 input logic [DATA_WIDTH-1:0] thr,
                                 input logic [DATA_WIDTH-1:0] bias_v,
                                 input logic [DATA_WIDTH-1:0] alpha_v);
        logic [nmac_pkg::CFG_INDEX_W-1:0] idx [5];
        logic [DATA_WIDTH-1:0]            data [5];
        idx[0] = nmac_pkg::CFG_INDEX_W'($urandom_range(nmac_pkg::CFG_ALPHA + 1,
                                                       (1 << nmac_pkg::CFG_INDEX_W) - 1));
        data[0] = DATA_WIDTH'($urandom);
        idx[1] = nmac_pkg::CFG_ACT_MODE;
        data[1] = (DATA_WIDTH'($urandom) << nmac_pkg::MODE_W) | DATA_WIDTH'(mode);
        idx[2] = nmac_pkg::CFG_THRESHOLD;
        data[2] = thr;
        idx[3] = nmac_pkg::CFG_BIAS;
        data[3] = bias_v;
        idx[4] = nmac_pkg::CFG_ALPHA;
        data[4] = alpha_v;
        for (int k = 0; k < 5; k++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx[k];
            cfg_data <= data[k];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // receiver: changing stall patterns, and a long hold-off when asked
    initial
    begin
        ready_pattern_t pattern;
        int span;
        out_ready = 1'b0;
        forever
        begin
            if (hold_off_req)
            begin
                @(posedge clk);
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_off_req = 1'b0;
            end
            pattern = ready_pattern_t'($urandom_range(0, 3));
            span = $urandom_range(16, 160);
            for (int n = 0; n < span && !hold_off_req; n++)
            begin
                @(posedge clk);
                case (pattern)
                    READY_ALWAYS:   out_ready <= 1'b1;
                    READY_COIN:     out_ready <= 1'($urandom_range(0, 1));
                    READY_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
                    READY_PERIODIC: out_ready <= (n % 3 == 0);
                    default:        out_ready <= 1'b1;
                endcase
            end
        end
    end

    initial
    begin
        int beats;
        int eval_len;
        logic [nmac_pkg::MODE_W-1:0] mode;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_value = '0;
        in_weight = '0;
        last = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: step at threshold zero, no bias
        send_beat(16'h0100, 16'h0100, 1'b1);
        send_beat(16'h0000, 16'h0000, 1'b1);
        send_beat(16'hff00, 16'h0100, 1'b1);
        send_beat(16'h0100, 16'h0100, 1'b0);
        send_beat(16'h8000, 16'h0001, 1'b1);
        stop_input();
        wait_for_results();

        // only the mode changes, so the leaky slope is still the reset alpha
        cfg_we <= 1'b1;
        cfg_index <= nmac_pkg::CFG_ACT_MODE;
        cfg_data <= DATA_WIDTH'(nmac_pkg::MODE_LEAKY);
        @(posedge clk);
        cfg_we <= 1'b0;
        send_beat(16'h8000, 16'h7fff, 1'b1);
        stop_input();
        wait_for_results();

        // every mode, the unused one too, with register extremes and extreme beats
        for (int m = 0; m < (1 << nmac_pkg::MODE_W); m++)
        begin
            mode = nmac_pkg::MODE_W'(m);
            load_settings(mode, mode[0] ? 16'h7fff : 16'h8000, mode[1] ? 16'h7fff : 16'h8000,
                          mode[2] ? 16'h8000 : 16'h7fff);
            send_beat(16'h7fff, 16'h7fff, 1'b1);
            send_beat(16'h8000, 16'h7fff, 1'b1);
            stop_input();
            wait_for_results();
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            load_settings(nmac_pkg::MODE_W'($urandom_range(0, (1 << nmac_pkg::MODE_W) - 1)),
                          rand_q88(), rand_q88(), rand_q88());
            max_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            // receiver holds off while the sender keeps pushing, so input stalls
            if (p % 8 == 3)
            begin
                hold_off_req = 1'b1;
                max_gap = 0;
            end
            beats = 0;
            while (beats < PHASE_BEATS)
            begin
                eval_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                       : $urandom_range(1, 4);
                for (int b = 1; b <= eval_len; b++)
                    send_beat(rand_q88(), rand_q88(), b == eval_len);
                beats += eval_len;
            end
            stop_input();
            wait_for_results();
        end

        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
design/nmac_pkg.sv
design/nmac_ctrl.sv
design/nmac_datapath.sv
design/neuron_mac_activation_core.sv
tb/neuron_result_checker.sv
tb/neuron_mac_activation_core_test.sv
